[rtl/ldm_pkg.sv]
// Shared types, codes and helpers for the LED matrix dot store.
package ldm_pkg;

    localparam int LDM_STORE_MODULES = 16;
    localparam int LDM_QUEUE_DEPTH   = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int ADDR_W     = 13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODULES_WIDE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULES_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECTION   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZIGZAG       = 3'd5;

    // request types
    localparam logic REQ_SET = 1'b0;
    localparam logic REQ_GET = 1'b1;

    // connection orientations
    localparam logic [2:0] CONN_LTR = 3'd0;
    localparam logic [2:0] CONN_RTL = 3'd1;
    localparam logic [2:0] CONN_RBL = 3'd2;
    localparam logic [2:0] CONN_LBR = 3'd3;
    localparam logic [2:0] CONN_LTD = 3'd4;
    localparam logic [2:0] CONN_RTD = 3'd5;
    localparam logic [2:0] CONN_RBU = 3'd6;
    localparam logic [2:0] CONN_LBU = 3'd7;

    // rotations, quarter turns clockwise
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam int MIR_X_BIT = 0;
    localparam int MIR_Y_BIT = 1;

    localparam logic [7:0] REV_MASK = 8'hF8;
    localparam logic [7:0] REV_LOW  = 8'd7;

    typedef struct packed {
        logic [4:0] modules_wide;
        logic [4:0] modules_high;
        logic [2:0] connection;
        logic [1:0] rotation;
        logic [1:0] mirror;
        logic       zigzag;
    } t_cfg;

    // mapped request handed from front to back
    typedef struct packed {
        logic        is_get;
        logic        dot_value;
        logic        off;
        logic [2:0]  bit_pos;
        logic [9:0]  p_row;
        logic [4:0]  col;
        logic [12:0] p_lane;
    } t_task;

    typedef struct packed {
        logic dot_read;
        logic off_panel;
    } t_result;

    // reverse the position inside an 8-dot block
    function automatic logic [7:0] rev8(input logic [7:0] v);
        return (v & REV_MASK) + (REV_LOW - (v & REV_LOW));
    endfunction

endpackage

[rtl/ldm_fifo.sv]
// Small synchronous FIFO used between front and back and for results.
module ldm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ldm_pkg::LDM_QUEUE_DEPTH   // power of two, at least 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import ldm_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + PW'(1);
            if (do_pop)  r_rp <= r_rp + PW'(1);
            if (do_push && !do_pop)      r_cnt <= r_cnt + CW'(1);
            else if (do_pop && !do_push) r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("queue count beyond depth");
`endif

endmodule

[rtl/ldm_front.sv]
// Front: maps a dot request to panel coordinates and address terms.
module ldm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ldm_pkg::t_cfg       i_cfg,
    input  logic                i_accept,
    input  logic                i_req_type,
    input  logic signed [9:0]   i_pos_x,
    input  logic signed [9:0]   i_pos_y,
    input  logic                i_dot_value,
    output logic                o_ready,
    output logic                o_task_push,
    output ldm_pkg::t_task      o_task,
    input  logic                i_task_full
);
    import ldm_pkg::*;

    typedef struct packed {
        logic       is_get;
        logic       dot_value;
        logic       off;
        logic [4:0] xb;
        logic [4:0] yb;
        logic [2:0] yl;
        logic [2:0] bit_pos;
    } t_map;

    logic signed [11:0] sx, sy, mx, my, cx, cy;
    logic [7:0]         x8, y8, t8;
    logic               off;
    t_map               map_d;
    t_map               r_a;
    logic               r_a_vld;
    t_task              task_d;
    t_task              r_b;
    logic               r_b_vld;
    logic [9:0]         r_wh;
    logic [4:0]         rows_below;
    logic               a_free;
    logic               b_free;

    // stage A: orientation, bounds, rotation, mirror, zigzag
    always_comb begin
        sx = {{2{i_pos_x[9]}}, i_pos_x};
        sy = {{2{i_pos_y[9]}}, i_pos_y};
        mx = {4'b0, i_cfg.modules_wide, 3'b0};
        my = {4'b0, i_cfg.modules_high, 3'b0};
        cx = sx;
        cy = sy;
        unique case (i_cfg.connection)
            CONN_LTR: begin
            end
            CONN_RTL: begin
                cx = mx - sx - 12'sd1;
                cy = {4'b0, rev8(sy[7:0])};
            end
            CONN_RBL: begin
                cx = mx - sx - 12'sd1;
                cy = my - sy - 12'sd1;
            end
            CONN_LBR: begin
                t8 = 8'(my - sy - 12'sd1);
                cy = {4'b0, rev8(t8)};
            end
            CONN_LTD: begin
                cx = sy;
                cy = {4'b0, rev8(sx[7:0])};
            end
            CONN_RTD: begin
                cx = sy;
                cy = my - sx - 12'sd1;
            end
            CONN_RBU: begin
                cx = mx - sy - 12'sd1;
                cy = my - signed'({4'b0, rev8(sx[7:0])}) - 12'sd1;
            end
            CONN_LBU: begin
                cx = mx - sy - 12'sd1;
                cy = sx;
            end
        endcase
        t8 = 8'(my - sy - 12'sd1);
        off = (cx < 12'sd0) || (cx >= mx) || (cy < 12'sd0) || (cy >= my);

        x8 = cx[7:0];
        y8 = cy[7:0];
        unique case (i_cfg.rotation)
            ROT_0: begin
            end
            ROT_90: begin
                y8 = {cy[7:3], cx[2:0]};
                x8 = {cx[7:3], ~cy[2:0]};
            end
            ROT_180: begin
                x8 = rev8(cx[7:0]);
                y8 = rev8(cy[7:0]);
            end
            ROT_270: begin
                y8 = {cy[7:3], ~cx[2:0]};
                x8 = {cx[7:3], cy[2:0]};
            end
        endcase
        if (i_cfg.mirror[MIR_X_BIT]) x8 = rev8(x8);
        if (i_cfg.mirror[MIR_Y_BIT]) y8 = rev8(y8);
        // odd module rows run the other way
        if (i_cfg.zigzag && y8[3]) begin
            x8 = mx[7:0] - 8'd1 - x8;
            y8 = rev8(y8);
        end

        map_d.is_get    = i_req_type;
        map_d.dot_value = i_dot_value;
        map_d.off       = off;
        map_d.xb        = x8[7:3];
        map_d.yb        = y8[7:3];
        map_d.yl        = y8[2:0];
        map_d.bit_pos   = x8[2:0];
    end

    // stage B: address products
    always_comb begin
        rows_below       = i_cfg.modules_high - 5'd1 - r_a.yb;
        task_d.is_get    = r_a.is_get;
        task_d.dot_value = r_a.dot_value;
        task_d.off       = r_a.off;
        task_d.bit_pos   = r_a.bit_pos;
        task_d.p_row     = 10'(i_cfg.modules_wide) * 10'(rows_below);
        task_d.col       = i_cfg.modules_wide - 5'd1 - r_a.xb;
        task_d.p_lane    = 13'(r_wh) * 13'(r_a.yl);
    end

    assign b_free      = !r_b_vld || !i_task_full;
    assign a_free      = !r_a_vld || b_free;
    assign o_ready     = a_free;
    assign o_task_push = r_b_vld && !i_task_full;
    assign o_task      = r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (a_free) r_a_vld <= i_accept;
            if (b_free) r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wh <= 10'(i_cfg.modules_wide) * 10'(i_cfg.modules_high);
        if (a_free && i_accept) r_a <= map_d;
        if (b_free && r_a_vld)  r_b <= task_d;
    end

endmodule

[rtl/ldm_back.sv]
// Back: clears the frame store, then reads the store per request and writes it back for a set.
module ldm_back #(
    parameter int STORE_MODULES = ldm_pkg::LDM_STORE_MODULES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ldm_pkg::t_task    i_task,
    input  logic              i_task_empty,
    output logic              o_task_pop,
    output logic              o_res_push,
    output ldm_pkg::t_result  o_res,
    input  logic              i_res_full,
    output logic              o_clearing
);
    import ldm_pkg::*;

    localparam int STORE_BYTES = STORE_MODULES * 8;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam logic [ADDR_W-1:0] STORE_END = ADDR_W'(STORE_BYTES);
    localparam logic [AW-1:0]     LAST_IDX  = AW'(STORE_BYTES - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [7:0]        mem [STORE_BYTES];
    logic [1:0]        r_state, n_state;
    logic [AW-1:0]     r_clr_idx;
    logic [ADDR_W-1:0] addr_sum;
    logic              miss;
    logic [7:0]        r_rd;
    logic [AW-1:0]     r_addr;
    logic              r_miss;
    logic              r_get;
    logic              r_val;
    logic [2:0]        r_bit;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [7:0]        mem_wdata;
    logic [7:0]        set_byte;

    assign addr_sum = {3'b0, i_task.p_row} + {8'b0, i_task.col} + i_task.p_lane;
    assign miss     = i_task.off || (addr_sum >= STORE_END);

    assign o_clearing = (r_state == ST_CLEAR);
    assign o_task_pop = (r_state == ST_IDLE) && !i_task_empty;
    assign o_res_push = (r_state == ST_EXEC) && !i_res_full;

    assign o_res.dot_read  = !r_miss && (r_get == REQ_GET) && r_rd[r_bit];
    assign o_res.off_panel = r_miss;

    assign set_byte = (r_rd & ~(8'd1 << r_bit)) | (8'(r_val) << r_bit);

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = set_byte;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                mem_wdata = 8'd0;
                if (r_clr_idx == LAST_IDX) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (o_task_pop) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (o_res_push) begin
                    mem_we  = !r_miss && (r_get == REQ_SET);
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_idx <= r_clr_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_task_pop) begin
            r_addr <= addr_sum[AW-1:0];
            r_miss <= miss;
            r_get  <= i_task.is_get;
            r_val  <= i_task.dot_value;
            r_bit  <= i_task.bit_pos;
        end
    end

    // single port store: one write or one registered read per cycle, never both
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (o_task_pop) r_rd <= mem[addr_sum[AW-1:0]];
    end

`ifndef SYNTHESIS
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_task_pop) else $error("task taken during clear");
    a_pop_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_task_pop |=> (r_state == ST_EXEC)) else $error("pop did not start access");
    a_push_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |=> (r_state == ST_IDLE) && !o_res_push)
        else $error("result pushed twice");
`endif

endmodule

[rtl/led_matrix_dot_store_top.sv]
// Frame store for a chained panel of 8x8 LED modules with set-dot and get-dot
// requests. After reset the store is cleared one byte at a time, during which
// full stays high. Configuration writes are taken at any time and registered.
// The front maps one request per cycle while the task queue has room, through
// a two-stage pipeline (orientation and bounds, then the address products)
// into a short queue. The back reads the single-port frame store, rewrites it
// for a set, and takes no new request until the last one has its result pushed,
// which sets the sustained rate. Every request gives exactly one result: the
// stored bit for a get, and off_panel high when the point or its address falls
// outside the panel or the store.
module led_matrix_dot_store_top #(
    parameter int STORE_MODULES = ldm_pkg::LDM_STORE_MODULES,
    parameter int QUEUE_DEPTH   = ldm_pkg::LDM_QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ldm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ldm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                               push,
    output logic                               full,
    input  logic                               i_req_type,
    input  logic signed [9:0]                  i_pos_x,
    input  logic signed [9:0]                  i_pos_y,
    input  logic                               i_dot_value,
    output logic                               empty,
    input  logic                               pop,
    output logic                               o_dot_read,
    output logic                               o_off_panel
);
    import ldm_pkg::*;

    t_cfg    r_cfg;
    logic    front_ready;
    logic    accept;
    logic    task_push;
    t_task   task_in;
    t_task   task_out;
    logic    task_full;
    logic    task_empty;
    logic    task_pop;
    logic    res_push;
    t_result res_in;
    t_result res_out;
    logic    res_full;
    logic    clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.modules_wide <= 5'd1;
            r_cfg.modules_high <= 5'd1;
            r_cfg.connection   <= CONN_LTR;
            r_cfg.rotation     <= ROT_0;
            r_cfg.mirror       <= 2'd0;
            r_cfg.zigzag       <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODULES_WIDE: r_cfg.modules_wide <= i_cfg_wdata;
                CFG_MODULES_HIGH: r_cfg.modules_high <= i_cfg_wdata;
                CFG_CONNECTION:   r_cfg.connection   <= i_cfg_wdata[2:0];
                CFG_ROTATION:     r_cfg.rotation     <= i_cfg_wdata[1:0];
                CFG_MIRROR:       r_cfg.mirror       <= i_cfg_wdata[1:0];
                CFG_ZIGZAG:       r_cfg.zigzag       <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign full   = !front_ready || clearing;
    assign accept = push && !full;

    ldm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_req_type  (i_req_type),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_dot_value (i_dot_value),
        .o_ready     (front_ready),
        .o_task_push (task_push),
        .o_task      (task_in),
        .i_task_full (task_full)
    );

    ldm_fifo #(
        .WIDTH ($bits(t_task)),
        .DEPTH (QUEUE_DEPTH)
    ) u_task_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (task_push),
        .i_data  (task_in),
        .o_full  (task_full),
        .i_pop   (task_pop),
        .o_data  (task_out),
        .o_empty (task_empty)
    );

    ldm_back #(
        .STORE_MODULES (STORE_MODULES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task       (task_out),
        .i_task_empty (task_empty),
        .o_task_pop   (task_pop),
        .o_res_push   (res_push),
        .o_res        (res_in),
        .i_res_full   (res_full),
        .o_clearing   (clearing)
    );

    ldm_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_dot_read  = res_out.dot_read;
    assign o_off_panel = res_out.off_panel;

endmodule

[dv/tb_led_matrix_dot_store_top.sv]
// Testbench for the LED matrix dot store: directed and random requests against a predictor.
`timescale 1ns / 100ps

module tb_led_matrix_dot_store_top;
    import ldm_pkg::*;

    localparam int STORE_BYTES    = LDM_STORE_MODULES * 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 400;
    localparam int MAX_GAP        = 60;
    localparam int RECENT_DEPTH   = 32;
    localparam int MAX_REPORTS    = 10;

    // register indexes past the end of the map
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE0 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE1 = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct {
        int x;
        int y;
    } t_point;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  push        = 1'b0;
    logic                  full;
    logic                  i_req_type  = REQ_SET;
    logic signed [9:0]     i_pos_x     = '0;
    logic signed [9:0]     i_pos_y     = '0;
    logic                  i_dot_value = 1'b0;
    logic                  empty;
    logic                  pop         = 1'b0;
    logic                  o_dot_read;
    logic                  o_off_panel;

    // predictor copy of the panel setup and the frame store
    logic [4:0] pnl_wide   = 5'd1;
    logic [4:0] pnl_high   = 5'd1;
    logic [2:0] pnl_conn   = CONN_LTR;
    logic [1:0] pnl_rot    = ROT_0;
    logic [1:0] pnl_mirror = 2'd0;
    logic       pnl_zigzag = 1'b1;
    logic [7:0] dot_mem [STORE_BYTES];

    t_result pending_dots[$];
    t_point  recent_sets[$];

    int send_idle_pct    = 0;
    int recv_stall_pct   = 0;
    int recv_hold_cycles = 0;
    int mismatch_count   = 0;
    int idle_cycles      = 0;

    led_matrix_dot_store_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_req_type  (i_req_type),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_dot_value (i_dot_value),
        .empty       (empty),
        .pop         (pop),
        .o_dot_read  (o_dot_read),
        .o_off_panel (o_off_panel)
    );

    always #5 i_clk = ~i_clk;

    // block helpers work on the low byte of the two's complement value
    function automatic int blk_hi(input int v);
        return v & int'(REV_MASK);
    endfunction

    function automatic int blk_lo(input int v);
        return v & int'(REV_LOW);
    endfunction

    function automatic int blk_rev(input int v);
        return blk_hi(v) + int'(REV_LOW) - blk_lo(v);
    endfunction

    // maps one request onto the store, applies a set, returns the response
    function automatic t_result access_dot(input logic req, input logic signed [9:0] px,
                                           input logic signed [9:0] py, input logic val);
        int          x, y, t, mx, my;
        int unsigned w, h, xu, yu, addr, bpos;
        t_result     r;
        r.dot_read  = 1'b0;
        r.off_panel = 1'b1;
        w  = pnl_wide;
        h  = pnl_high;
        mx = int'(w) * 8;
        my = int'(h) * 8;
        x  = px;
        y  = py;
        case (pnl_conn)
            CONN_RTL: begin
                x = mx - x - 1;
                y = blk_rev(y);
            end
            CONN_RBL: begin
                y = my - y - 1;
                x = mx - x - 1;
            end
            CONN_LBR: begin
                y = my - y - 1;
                y = blk_rev(y);
            end
            CONN_LTD: begin
                t = x;
                x = y;
                y = blk_rev(t);
            end
            CONN_RTD: begin
                t = x;
                x = y;
                y = my - t - 1;
            end
            CONN_RBU: begin
                t = x;
                x = mx - y - 1;
                y = my - blk_rev(t) - 1;
            end
            CONN_LBU: begin
                t = x;
                x = mx - y - 1;
                y = t;
            end
            default: ;
        endcase
        if (x < 0 || x >= mx || y < 0 || y >= my)
            return r;

        t = y;
        case (pnl_rot)
            ROT_90: begin
                y = blk_hi(y) + blk_lo(x);
                x = blk_hi(x) + int'(REV_LOW) - blk_lo(t);
            end
            ROT_180: begin
                x = blk_rev(x);
                y = blk_rev(y);
            end
            ROT_270: begin
                y = blk_hi(y) + int'(REV_LOW) - blk_lo(x);
                x = blk_hi(x) + blk_lo(t);
            end
            default: ;
        endcase
        if (pnl_mirror[MIR_X_BIT])
            x = blk_rev(x);
        if (pnl_mirror[MIR_Y_BIT])
            y = blk_rev(y);
        // odd module rows run the other way
        if (pnl_zigzag && ((y >> 3) & 1) != 0) begin
            x = mx - 1 - x;
            y = blk_rev(y);
        end

        xu   = x;
        yu   = y;
        bpos = xu & 7;
        addr = w * (h - 1 - (yu >> 3)) + (w - 1 - (xu >> 3)) + (yu & 7) * w * h;
        if (addr >= STORE_BYTES)
            return r;

        r.off_panel = 1'b0;
        if (req == REQ_GET)
            r.dot_read = dot_mem[addr][bpos];
        else
            dot_mem[addr][bpos] = val;
        return r;
    endfunction

    function automatic int rand_coord(input int span);
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return int'($urandom_range(span - 1));
        if (sel < 82) begin
            if ($urandom_range(1))
                return -int'($urandom_range(2));
            return span - 1 + int'($urandom_range(2));
        end
        // folds back into the panel through the in-module reversal
        if (sel < 90)
            return int'($urandom_range(span - 1)) + ($urandom_range(1) ? 256 : -256);
        return int'($urandom_range(1023)) - 512;
    endfunction

    // one register write; leaves the write enable high for a following write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data[CFG_DATA_W-1:0];
        @(posedge i_clk);
        case (idx)
            CFG_MODULES_WIDE: pnl_wide   = data[4:0];
            CFG_MODULES_HIGH: pnl_high   = data[4:0];
            CFG_CONNECTION:   pnl_conn   = data[2:0];
            CFG_ROTATION:     pnl_rot    = data[1:0];
            CFG_MIRROR:       pnl_mirror = data[1:0];
            CFG_ZIGZAG:       pnl_zigzag = data[0];
            default: ;
        endcase
    endtask

    task automatic program_panel(input int w, input int h, input int conn,
                                 input int rot, input int mir, input int zz);
        cfg_write(CFG_MODULES_WIDE, w);
        cfg_write(CFG_MODULES_HIGH, h);
        cfg_write(CFG_CONNECTION, conn);
        cfg_write(CFG_ROTATION, rot);
        cfg_write(CFG_MIRROR, mir);
        cfg_write(CFG_ZIGZAG, zz);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_SENDER: begin
                send_idle_pct  = 74;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 74;
            end
            IDLE_BOTH: begin
                send_idle_pct  = 27;
                recv_stall_pct = 27;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // called at a rising edge; push stays high when no gap follows
    task automatic send_dot(input logic req, input int px, input int py, input logic val);
        int     gap;
        t_point p;
        push        <= 1'b1;
        i_req_type  <= req;
        i_pos_x     <= px[9:0];
        i_pos_y     <= py[9:0];
        i_dot_value <= val;
        @(posedge i_clk);
        while (full !== 1'b0)
            @(posedge i_clk);
        pending_dots.push_back(access_dot(req, px[9:0], py[9:0], val));
        if (req == REQ_SET) begin
            p.x = px;
            p.y = py;
            recent_sets.push_back(p);
            if (recent_sets.size() > RECENT_DEPTH)
                void'(recent_sets.pop_front());
        end
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_dot();
        int     span, px, py;
        logic   req, val;
        t_point p;
        span = int'((pnl_wide > pnl_high) ? pnl_wide : pnl_high) * 8;
        if (span == 0)
            span = 8;
        req = 1'($urandom_range(1));
        val = 1'($urandom_range(1));
        // gets mostly revisit recent writes so stored bits are read back
        if (req == REQ_GET && recent_sets.size() != 0 && $urandom_range(99) < 60) begin
            p  = recent_sets[$urandom_range(recent_sets.size() - 1)];
            px = p.x;
            py = p.y;
        end else begin
            px = rand_coord(span);
            py = rand_coord(span);
        end
        send_dot(req, px, py, val);
    endtask

    task automatic wait_drain();
        push <= 1'b0;
        while (pending_dots.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int w, input int h, input int conn, input int rot,
                             input int mir, input int zz, input t_idle_mode mode,
                             input int count);
        wait_drain();
        program_panel(w, h, conn, rot, mir, zz);
        set_idling(mode);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2)
                wait_drain();
            send_random_dot();
        end
    endtask

    task automatic test_reset_state();
        set_idling(IDLE_NONE);
        send_dot(REQ_GET, 0, 0, 1'b0);
        send_dot(REQ_SET, 0, 0, 1'b1);
        send_dot(REQ_GET, 0, 0, 1'b0);
        send_dot(REQ_SET, 7, 7, 1'b1);
        send_dot(REQ_GET, 7, 7, 1'b1);
        send_dot(REQ_GET, -1, 0, 1'b0);
        send_dot(REQ_GET, 8, 0, 1'b0);
        send_dot(REQ_GET, 0, -1, 1'b0);
        send_dot(REQ_GET, 0, 8, 1'b0);
        send_dot(REQ_SET, -512, -512, 1'b1);
        send_dot(REQ_SET, 511, 511, 1'b1);
        send_dot(REQ_SET, 0, 0, 1'b0);
        send_dot(REQ_GET, 0, 0, 1'b0);
        wait_drain();
    endtask

    task automatic test_unused_index();
        cfg_write(CFG_IDX_SPARE0, 31);
        cfg_write(CFG_IDX_SPARE1, 31);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        send_dot(REQ_GET, 7, 7, 1'b0);
        send_dot(REQ_SET, 3, 3, 1'b1);
        wait_drain();
    endtask

    task automatic test_special_cases();
        // negative and 9-bit coordinates folding into the panel
        program_panel(1, 1, CONN_RTL, ROT_0, 0, 1);
        send_dot(REQ_GET, 0, 259, 1'b0);
        send_dot(REQ_SET, 2, -253, 1'b1);
        send_dot(REQ_GET, 2, 3, 1'b0);
        wait_drain();
        // no modules: nothing is on the panel
        program_panel(0, 1, CONN_LTR, ROT_0, 0, 1);
        send_dot(REQ_SET, 0, 0, 1'b1);
        send_dot(REQ_GET, 0, 0, 1'b0);
        wait_drain();
        // panel larger than the store
        program_panel(16, 2, CONN_LTR, ROT_0, 0, 0);
        send_dot(REQ_SET, 0, 7, 1'b1);
        send_dot(REQ_GET, 0, 7, 1'b0);
        send_dot(REQ_SET, 127, 8, 1'b1);
        send_dot(REQ_GET, 127, 8, 1'b0);
        wait_drain();
    endtask

    task automatic test_random_phases();
        int w, h;
        run_phase(1, 1, CONN_LTR, ROT_0, 0, 1, IDLE_NONE, 40);
        run_phase(2, 2, CONN_RTL, ROT_90, 1, 0, IDLE_SENDER, 50);
        run_phase(4, 4, CONN_RBL, ROT_180, 2, 1, IDLE_RECEIVER, 50);
        run_phase(16, 1, CONN_LBR, ROT_270, 3, 0, IDLE_BOTH, 50);
        run_phase(1, 16, CONN_LTD, ROT_0, 1, 1, IDLE_NONE, 50);
        run_phase(8, 2, CONN_RTD, ROT_90, 2, 1, IDLE_SENDER, 50);
        run_phase(2, 8, CONN_RBU, ROT_180, 3, 0, IDLE_RECEIVER, 50);
        run_phase(4, 2, CONN_LBU, ROT_270, 0, 1, IDLE_BOTH, 50);
        run_phase(16, 16, $urandom_range(7), $urandom_range(3), $urandom_range(3),
                  $urandom_range(1), IDLE_NONE, 30);
        run_phase(31, 31, $urandom_range(7), $urandom_range(3), $urandom_range(3),
                  $urandom_range(1), IDLE_SENDER, 20);
        run_phase(0, 3, $urandom_range(7), $urandom_range(3), $urandom_range(3),
                  $urandom_range(1), IDLE_RECEIVER, 20);
        for (int k = 0; k < 3; k++) begin
            w = $urandom_range(16, 1);
            h = $urandom_range(16 / w, 1);
            run_phase(w, h, $urandom_range(7), $urandom_range(3), $urandom_range(3),
                      $urandom_range(1), t_idle_mode'(k + 1), 60);
        end
        wait_drain();
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_back_pressure();
        program_panel(4, 4, CONN_LTD, ROT_90, 1, 1);
        set_idling(IDLE_NONE);
        recv_hold_cycles = LONG_HOLD;
        repeat (12) send_random_dot();
        wait_drain();
    endtask

    // receive side: random stalls, long hold-off, and result checking
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && pop && empty === 1'b0) begin
            if (pending_dots.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected transaction: dot_read %0b off_panel %0b",
                             o_dot_read, o_off_panel);
            end else begin
                want = pending_dots.pop_front();
                if (want.dot_read !== o_dot_read || want.off_panel !== o_off_panel) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: dot_read exp %0b got %0b, off_panel exp %0b got %0b",
                                 want.dot_read, o_dot_read, want.off_panel, o_off_panel);
                end
            end
        end
        if (recv_hold_cycles > 0) begin
            pop <= 1'b0;
            recv_hold_cycles--;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge i_clk) begin
        if ((push && full === 1'b0) || (pop && empty === 1'b0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < STORE_BYTES; k++)
            dot_mem[k] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_unused_index();
        test_special_cases();
        test_back_pressure();
        test_random_phases();
        wait_drain();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
